>>> rtl/bibe_pkg.sv
// Package for the 4-neighbor inner boundary extractor.
// Holds pixel type, register indexes, field widths and default sizes.
// Used by binary_inner_boundary_extract_core; depends on nothing.
package bibe_pkg;

	localparam int PIX_W       = 16;
	localparam int IMG_W_BITS  = 11;
	localparam int IMG_H_BITS  = 13;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 13;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 4096;
	localparam int RESET_WIDTH    = 1024;
	localparam int RESET_HEIGHT   = 1024;

	typedef logic signed [PIX_W-1:0] pix_t;
	typedef logic [CFG_IDX_W-1:0]    cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

	localparam cfg_idx_t REG_IMAGE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_IMAGE_HEIGHT = 2'd1;

	localparam pix_t PIX_ONE = 16'sd1;

endpackage

>>> rtl/binary_inner_boundary_extract_core.sv
// Top level of the 4-neighbor inner boundary extractor (line buffer based).
// Depends on bibe_pkg for types, register indexes and default sizes.
//
// channel   dir   handshake           payload
// in        in    in_valid/in_stall   in_pixel, flush
// out       out   out_valid/out_stall out_pixel, frame_last
// cfg       in    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One beat per clock while in_stall is low: each pixel sees its row-above
// value and right neighbor from two line-buffer RAMs read ahead at the next
// column, then the result lands in the output register. Output lags input
// by one row. in_stall rises only while a result sits in the output register
// and the sink stalls. cfg_ready is always high; a width or height write
// restarts the slice. Reset clears counters, flags and out_valid and loads
// the default sizes; RAM contents stay and are never used before written.
module binary_inner_boundary_extract_core #(
	parameter int MAX_WIDTH  = bibe_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bibe_pkg::MAX_HEIGHT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  bibe_pkg::pix_t      in_pixel,
	input  logic                flush,
	output logic                out_valid,
	input  logic                out_stall,
	output bibe_pkg::pix_t      out_pixel,
	output logic                frame_last,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  bibe_pkg::cfg_idx_t  cfg_index,
	input  bibe_pkg::cfg_data_t cfg_data
);
	import bibe_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 1);
	localparam int W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	// configuration
	logic [WW-1:0] width_q, width_wr;
	logic [RW-1:0] height_q, height_wr;
	logic [31:0]   w_ext, h_ext;
	logic          cfg_fire, cfg_hit;

	// counters and flags
	logic [AW-1:0] col_q, col_nxt;
	logic [RW-1:0] row_q;
	logic          left_q;

	// line buffers and their read-ahead registers
	pix_t          row_mem [MAX_WIDTH];
	logic          up_mem  [MAX_WIDTH];
	pix_t          rd_raw_q, byp_pix_q, first_q, cur_q, right_pix;
	logic          rd_byp_q, up_raw_q, up_byp_q, up_byp_val_q, up_one;
	logic [AW-1:0] rd_addr;

	// output register
	pix_t          out_pix_q;
	logic          out_last_q, out_vld_q;

	logic          in_fire, drain, last_col, pix_we, up_we, emit, interior;
	logic          old_one, right_one;
	pix_t          emit_pix;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_hit   = cfg_fire &&
		(cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	assign w_ext = 32'(cfg_data[IMG_W_BITS-1:0]);
	assign h_ext = 32'(cfg_data[IMG_H_BITS-1:0]);

	always_comb begin
		if (w_ext == 32'd0) begin
			width_wr = WW'(1);
		end else if (w_ext > 32'(MAX_WIDTH)) begin
			width_wr = WW'(MAX_WIDTH);
		end else begin
			width_wr = WW'(w_ext);
		end
		if (h_ext == 32'd0) begin
			height_wr = RW'(1);
		end else if (h_ext > 32'(MAX_HEIGHT)) begin
			height_wr = RW'(MAX_HEIGHT);
		end else begin
			height_wr = RW'(h_ext);
		end
	end

	assign in_stall  = out_vld_q && out_stall;
	assign in_fire   = in_valid && !in_stall;
	assign drain     = (row_q >= height_q);
	assign last_col  = ((WW'(col_q) + WW'(1)) == width_q);

	// bypass covers a read-ahead that hits the column written this beat
	assign right_pix = rd_byp_q ? byp_pix_q : rd_raw_q;
	assign up_one    = up_byp_q ? up_byp_val_q : up_raw_q;

	assign old_one   = (cur_q == PIX_ONE);
	assign right_one = !last_col && (right_pix == PIX_ONE);
	assign interior  = (row_q > RW'(1)) && (col_q != '0) && right_one && up_one
		&& left_q && (in_pixel == PIX_ONE);

	assign pix_we = in_fire && !drain && !flush;
	assign up_we  = pix_we && (row_q != '0);
	assign emit   = in_fire && (drain || (!flush && row_q != '0));
	assign emit_pix = (!drain && interior) ? '0 : cur_q;

	always_comb begin
		col_nxt = col_q;
		if (cfg_hit) begin
			col_nxt = '0;
		end else if (in_fire && (drain || !flush)) begin
			col_nxt = last_col ? '0 : col_q + AW'(1);
		end
	end

	// one column past the next beat's column; wraps out of range when unused
	assign rd_addr = col_nxt + AW'(1);

	always_ff @(posedge clk) begin
		if (pix_we) begin
			row_mem[col_q] <= in_pixel;
		end
		rd_raw_q <= row_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (up_we) begin
			up_mem[col_q] <= old_one;
		end
		up_raw_q <= up_mem[col_nxt];
	end

	always_ff @(posedge clk) begin
		rd_byp_q     <= pix_we && (rd_addr == col_q);
		byp_pix_q    <= in_pixel;
		up_byp_q     <= up_we && (col_nxt == col_q);
		up_byp_val_q <= old_one;
		if (pix_we && col_q == '0) begin
			first_q <= in_pixel;
		end
		// hold the value stored at the current column
		if (in_fire && (drain || !flush)) begin
			if (!last_col) begin
				cur_q <= right_pix;
			end else if (col_q == '0) begin
				cur_q <= in_pixel;
			end else begin
				cur_q <= first_q;
			end
		end
		if (emit) begin
			out_pix_q  <= emit_pix;
			out_last_q <= drain && last_col;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= WW'(W_RST);
			height_q  <= RW'(H_RST);
			col_q     <= '0;
			row_q     <= '0;
			left_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
			col_q <= col_nxt;
			if (cfg_hit) begin
				if (cfg_index == REG_IMAGE_WIDTH) begin
					width_q <= width_wr;
				end else begin
					height_q <= height_wr;
				end
				row_q  <= '0;
				left_q <= 1'b0;
			end else if (in_fire) begin
				if (drain) begin
					if (last_col) begin
						row_q  <= '0;
						left_q <= 1'b0;
					end
				end else if (!flush) begin
					if (row_q != '0) begin
						left_q <= old_one;
					end
					if (last_col) begin
						row_q  <= row_q + RW'(1);
						left_q <= 1'b0;
					end
				end
			end
		end
	end

	assign out_valid  = out_vld_q;
	assign out_pixel  = out_pix_q;
	assign frame_last = out_last_q;

endmodule
